[rtl/core/dqk_pkg.sv]
// ----------------------------------------------------------------------------
// dqk_pkg
// Shared types, command codes and the quadrature step table for the knob
// decoder.
// ----------------------------------------------------------------------------
package dqk_pkg;

  localparam int CountW   = 32;
  localparam int TimeW    = 32;
  localparam int DebW     = 16;
  localparam int CmdW     = 3;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_EDGE       = 3'd0,
    CMD_PRESS      = 3'd1,
    CMD_READ       = 3'd2,
    CMD_READ_VALUE = 3'd3,
    CMD_CLEAR      = 3'd4
  } dqk_cmd_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } dqk_step_t;

  typedef struct packed {
    logic [CountW-1:0] live_count;
    logic [CountW-1:0] shown_count;
    logic              press_latch;
    logic              shown_press;
    logic [1:0]        prior_phase;
    logic [TimeW-1:0]  last_edge_ms;
  } dqk_state_t;

  // phase code is {phase_b, phase_a}
  function automatic dqk_step_t quad_step(input logic [1:0] old_ph, input logic [1:0] new_ph);
    dqk_step_t s;
    case ({old_ph, new_ph})
      4'b0001: s = STEP_DOWN;
      4'b0010: s = STEP_UP;
      4'b0100: s = STEP_UP;
      4'b0111: s = STEP_DOWN;
      4'b1000: s = STEP_DOWN;
      4'b1011: s = STEP_UP;
      4'b1101: s = STEP_UP;
      4'b1110: s = STEP_DOWN;
      default: s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/dqk_update.sv]
// ----------------------------------------------------------------------------
// dqk_update
// Next-state logic for one command: debounce gate, quadrature step, press
// latch, publish and clear.
// ----------------------------------------------------------------------------
module dqk_update
  import dqk_pkg::*;
(
  input  dqk_state_t        cur,
  input  logic [CmdW-1:0]   command,
  input  logic              phase_a,
  input  logic              phase_b,
  input  logic [TimeW-1:0]  now_ms,
  input  logic [DebW-1:0]   debounce_ms,
  output dqk_state_t        nxt
);

  logic [TimeW-1:0] elapsed;
  logic             gate_open;
  logic [1:0]       phase;
  dqk_step_t        step;

  assign elapsed   = now_ms - cur.last_edge_ms;
  assign gate_open = (elapsed >= {{(TimeW-DebW){1'b0}}, debounce_ms});
  assign phase     = {phase_b, phase_a};
  assign step      = quad_step(cur.prior_phase, phase);

  always_comb begin
    nxt = cur;
    case (command)
      CMD_EDGE: begin
        if (gate_open) begin
          case (step)
            STEP_UP:   nxt.live_count = cur.live_count + {{(CountW-1){1'b0}}, 1'b1};
            STEP_DOWN: nxt.live_count = cur.live_count - {{(CountW-1){1'b0}}, 1'b1};
            default:   nxt.live_count = cur.live_count;
          endcase
          nxt.prior_phase  = phase;
          nxt.last_edge_ms = now_ms;
        end
      end
      CMD_PRESS: begin
        nxt.press_latch = 1'b1;
      end
      CMD_READ: begin
        nxt.shown_press = cur.press_latch;
        nxt.press_latch = 1'b0;
        nxt.shown_count = cur.live_count;
      end
      CMD_READ_VALUE: begin
        nxt.shown_count = cur.live_count;
      end
      CMD_CLEAR: begin
        nxt = '0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

[rtl/core/debounced_quadrature_knob.sv]
// ----------------------------------------------------------------------------
// debounced_quadrature_knob
// Rotary knob decoder with a millisecond debounce gate and press latch.
// ----------------------------------------------------------------------------
// usage:
//   in_* channel carries one command per beat: edge (phase levels plus
//   timestamp), press, read (count and press flag, clears the latch),
//   read_value (count only) or clear. unused codes leave state alone.
//   out_* channel returns exactly one beat per command with the published
//   count and press flag after that command.
//   the whole update is one level of logic between the decoder state and
//   the result register: out_valid rises in the cycle after the input
//   beat, and one beat is taken every cycle while the output is drained.
//   in_ready drops only while a result is held and out_ready is low; the
//   held result stays put until taken, and the next beat is taken in the
//   same cycle the held one leaves.
//   apb register 0 (debounce_ms, 16 bits) is written at any address; write
//   it only while no beat is in flight.
//   synchronous reset clears all decoder state, debounce_ms and out_valid.
// ----------------------------------------------------------------------------
module debounced_quadrature_knob
  import dqk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CmdW-1:0]      in_command,
  input  logic                 in_phase_a,
  input  logic                 in_phase_b,
  input  logic [TimeW-1:0]     in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CountW-1:0] out_count,
  output logic                 out_pressed,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ApbAddrW-1:0]  paddr,
  input  logic [ApbDataW-1:0]  pwdata,
  output logic [ApbDataW-1:0]  prdata,
  output logic                 pready
);

  dqk_state_t              state_r, state_nxt;
  logic [DebW-1:0]         debounce_r;
  logic                    out_valid_r;
  logic [CountW-1:0]       out_count_r;
  logic                    out_pressed_r;
  logic                    in_fire;
  logic                    cfg_wr;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // single register, every address maps onto it
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == '0) ? {{(ApbDataW-DebW){1'b0}}, debounce_r}
                                : {{(ApbDataW-DebW){1'b0}}, debounce_r};

  dqk_update u_update (
    .cur         (state_r),
    .command     (in_command),
    .phase_a     (in_phase_a),
    .phase_b     (in_phase_b),
    .now_ms      (in_now_ms),
    .debounce_ms (debounce_r),
    .nxt         (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      debounce_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        debounce_r <= pwdata[DebW-1:0];
      end
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_count_r   <= state_nxt.shown_count;
      out_pressed_r <= state_nxt.shown_press;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_count   = signed'(out_count_r);
  assign out_pressed = out_pressed_r;

endmodule

[rtl/core/dqk_checker.sv]
// ----------------------------------------------------------------------------
// dqk_checker
// Port-level checks for the knob decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dqk_checker
  import dqk_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CmdW-1:0]      in_command,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [CountW-1:0] out_count,
  input  logic                 out_pressed
);

  // a held result must not change while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_pressed))
    else $error("stalled result changed");

  // back pressure only while a result is waiting
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without a stalled result");

  // every accepted beat shows up as a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat gave no result");

  // clear publishes zeros
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_CLEAR |=> out_count == '0 && !out_pressed)
    else $error("clear did not publish zero");

  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind debounced_quadrature_knob dqk_checker u_dqk_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_command  (in_command),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_count   (out_count),
  .out_pressed (out_pressed)
);
